// ===== sv/gcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Garner CRT reconstruction core.
// No dependencies.
package gcr_pkg;

    localparam int FIELD_W   = 32;
    localparam int NUM_RES   = 3;
    localparam int IN_W      = NUM_RES * FIELD_W;
    localparam int OUT_W     = 96;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOD_ZERO    = 3'd0,
        CFG_MOD_ONE     = 3'd1,
        CFG_MOD_TWO     = 3'd2,
        CFG_CONST_ONE   = 3'd3,
        CFG_CONST_TWO   = 3'd4
    } t_cfg_idx;

    // (a - b) mod m for a, b already below m
    function automatic logic [FIELD_W-1:0] mod_sub(
        input logic [FIELD_W-1:0] a,
        input logic [FIELD_W-1:0] b,
        input logic [FIELD_W-1:0] m
    );
        logic [FIELD_W:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + {1'b0, m} - {1'b0, b};
        end
        return t[FIELD_W-1:0];
    endfunction

endpackage

// ===== sv/garner_crt_reconstruct_core.sv =====
`timescale 1ns / 1ps
// Top level of the Garner CRT reconstruction core.
// Depends on gcr_pkg, gcr_step and gcr_mod_pipe.
//
// Rebuilds a coefficient from its residues modulo two or three moduli with
// Garner's mixed-radix method and returns it as a 96-bit value. One transfer is
// taken every cycle while the output transfer is not stalled; the bit-serial
// remainder pipelines use one stage per dividend bit, followed by one output
// register. The whole pipeline advances together and holds while the output
// transfer is stalled. Moduli and constants must be written only while no
// transfer is in flight.
module garner_crt_reconstruct_core #(
    parameter int NUM_MODULI   = 3,
    parameter int RESIDUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // residue_zero, residue_one, residue_two
    input  logic [gcr_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // value_low, value_high
    output logic [gcr_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [gcr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gcr_pkg::FIELD_W-1:0]     i_cfg_data
);
    import gcr_pkg::*;

    localparam int W  = RESIDUE_BITS;
    localparam int XF = NUM_MODULI * W;

    logic [FIELD_W-1:0] r_mod0, r_mod1, r_mod2, r_c1, r_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod0 <= FIELD_W'(2);
            r_mod1 <= FIELD_W'(2);
            r_mod2 <= FIELD_W'(2);
            r_c1   <= '0;
            r_c2   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MOD_ZERO:  r_mod0 <= i_cfg_data;
                CFG_MOD_ONE:   r_mod1 <= i_cfg_data;
                CFG_MOD_TWO:   r_mod2 <= i_cfg_data;
                CFG_CONST_ONE: r_c1   <= i_cfg_data;
                CFG_CONST_TWO: r_c2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic       w_en;
    logic       r_out_vld;
    logic [OUT_W-1:0] r_out_data;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    logic [W-1:0]   w_res0, w_res1, w_res2;
    assign w_res0 = s_axis_tdata[0 +: W];
    assign w_res1 = s_axis_tdata[FIELD_W +: W];
    assign w_res2 = s_axis_tdata[2*FIELD_W +: W];

    logic           s1_valid;
    logic [2*W-1:0] s1_x;
    logic [W-1:0]   s1_pay;

    gcr_step #(.W(W), .NCH(1), .PAYW(W)) u_step1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_axis_tvalid),
        .i_x      (w_res0),
        .i_res    (w_res1),
        .i_pay    (w_res2),
        .i_mod    (r_mod1[W-1:0]),
        .i_const  (r_c1[W-1:0]),
        .i_prefix (r_mod0[W-1:0]),
        .o_valid  (s1_valid),
        .o_x      (s1_x),
        .o_pay    (s1_pay)
    );

    logic          w_fin_vld;
    logic [XF-1:0] w_fin_x;

    if (NUM_MODULI == 3) begin : g_three
        logic [2*W-1:0] r_prefix;
        logic [0:0]     s2_pay;

        // product of the first two moduli; settles long before an item gets here
        always_ff @(posedge i_clk) begin
            r_prefix <= (2*W)'(r_mod0[W-1:0]) * (2*W)'(r_mod1[W-1:0]);
        end

        gcr_step #(.W(W), .NCH(2), .PAYW(1)) u_step2 (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (s1_valid),
            .i_x      (s1_x),
            .i_res    (s1_pay),
            .i_pay    (1'b0),
            .i_mod    (r_mod2[W-1:0]),
            .i_const  (r_c2[W-1:0]),
            .i_prefix (r_prefix),
            .o_valid  (w_fin_vld),
            .o_x      (w_fin_x),
            .o_pay    (s2_pay)
        );
    end else begin : g_two
        assign w_fin_vld = s1_valid;
        assign w_fin_x   = s1_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= OUT_W'(w_fin_x);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== sv/gcr_mod_pipe.sv =====
`timescale 1ns / 1ps
// Pipelined restoring remainder unit: one dividend bit per stage, several lanes
// sharing one modulus, with a side payload that travels along. No package use.
module gcr_mod_pipe #(
    parameter int NW    = 32,
    parameter int MW    = 32,
    parameter int LANES = 1,
    parameter int PAYW  = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [LANES-1:0][NW-1:0]   i_num,
    input  logic [MW-1:0]              i_mod,
    input  logic [PAYW-1:0]            i_pay,
    output logic                       o_valid,
    output logic [LANES-1:0][MW-1:0]   o_rem,
    output logic [PAYW-1:0]            o_pay
);

    logic                     r_vld [NW];
    logic [LANES-1:0][MW-1:0] r_rem [NW];
    logic [LANES-1:0][NW-1:0] r_num [NW-1];
    logic [PAYW-1:0]          r_pay [NW];
    logic [LANES-1:0][MW-1:0] n_rem [NW];

    genvar k;
    for (k = 0; k < NW; k++) begin : g_stage
        logic                     w_vld;
        logic [LANES-1:0][MW-1:0] w_rem;
        logic [LANES-1:0][NW-1:0] w_num;
        logic [PAYW-1:0]          w_pay;

        if (k == 0) begin : g_first
            assign w_vld = i_valid;
            assign w_rem = '0;
            assign w_num = i_num;
            assign w_pay = i_pay;
        end else begin : g_next
            assign w_vld = r_vld[k-1];
            assign w_rem = r_rem[k-1];
            assign w_num = r_num[k-1];
            assign w_pay = r_pay[k-1];
        end

        // shift in the next dividend bit, subtract the modulus if it fits
        always_comb begin
            logic [MW:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = {w_rem[l], w_num[l][NW-1-k]};
                if (trial >= {1'b0, i_mod}) begin
                    trial = trial - {1'b0, i_mod};
                end
                n_rem[k][l] = trial[MW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem[k];
                r_pay[k] <= w_pay;
            end
        end

        if (k < NW - 1) begin : g_num
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k] <= w_num;
                end
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_pay   = r_pay[NW-1];

endmodule

// ===== sv/gcr_step.sv =====
`timescale 1ns / 1ps
// One Garner step: u = ((r - x) * C) mod m, then x + u * prefix.
// Depends on gcr_pkg and gcr_mod_pipe.
module gcr_step #(
    parameter int W    = 32,
    parameter int NCH  = 1,
    parameter int PAYW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NCH*W-1:0]     i_x,
    input  logic [W-1:0]         i_res,
    input  logic [PAYW-1:0]      i_pay,
    input  logic [W-1:0]         i_mod,
    input  logic [W-1:0]         i_const,
    input  logic [NCH*W-1:0]     i_prefix,
    output logic                 o_valid,
    output logic [(NCH+1)*W-1:0] o_x,
    output logic [PAYW-1:0]      o_pay
);
    import gcr_pkg::*;

    localparam int XW  = NCH * W;
    localparam int XO  = (NCH + 1) * W;
    localparam int CW  = XW + PAYW;
    localparam int PW2 = 2 * W;

    // x mod m and r mod m side by side
    logic                     a_valid;
    logic [1:0][XW-1:0]       a_num;
    logic [1:0][W-1:0]        a_rem;
    logic [CW-1:0]            a_pay;

    assign a_num[0] = i_x;
    assign a_num[1] = XW'(i_res);

    gcr_mod_pipe #(.NW(XW), .MW(W), .LANES(2), .PAYW(CW)) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_num   (a_num),
        .i_mod   (i_mod),
        .i_pay   ({i_x, i_pay}),
        .o_valid (a_valid),
        .o_rem   (a_rem),
        .o_pay   (a_pay)
    );

    // difference and product with the Garner constant
    logic [W-1:0]   w_diff;
    logic [PW2-1:0] n_b_prod;
    logic           r_b_vld;
    logic [PW2-1:0] r_b_prod;
    logic [CW-1:0]  r_b_pay;

    assign w_diff   = W'(mod_sub(FIELD_W'(a_rem[1]), FIELD_W'(a_rem[0]), FIELD_W'(i_mod)));
    assign n_b_prod = PW2'(w_diff) * PW2'(i_const);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_prod <= n_b_prod;
            r_b_pay  <= a_pay;
        end
    end

    // (diff * C) mod m
    logic                  c_valid;
    logic [0:0][W-1:0]     c_rem;
    logic [CW-1:0]         c_pay;

    gcr_mod_pipe #(.NW(PW2), .MW(W), .LANES(1), .PAYW(CW)) u_prod_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_b_vld),
        .i_num   (r_b_prod),
        .i_mod   (i_mod),
        .i_pay   (r_b_pay),
        .o_valid (c_valid),
        .o_rem   (c_rem),
        .o_pay   (c_pay)
    );

    // partial products of u with each W-bit chunk of the prefix
    logic [W-1:0]   w_u;
    logic [PW2-1:0] n_d_pp [NCH];
    logic           r_d_vld;
    logic [PW2-1:0] r_d_pp [NCH];
    logic [CW-1:0]  r_d_pay;

    // zero modulus gives u = 0
    assign w_u = (i_mod == '0) ? '0 : c_rem[0];

    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            n_d_pp[j] = PW2'(w_u) * PW2'(i_prefix[j*W +: W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_pp  <= n_d_pp;
            r_d_pay <= c_pay;
        end
    end

    // accumulate
    logic [XO-1:0]   n_e_x;
    logic            r_e_vld;
    logic [XO-1:0]   r_e_x;
    logic [PAYW-1:0] r_e_pay;

    always_comb begin
        n_e_x = XO'(r_d_pay[CW-1:PAYW]);
        for (int j = 0; j < NCH; j++) begin
            n_e_x = n_e_x + (XO'(r_d_pp[j]) << (j * W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_x   <= n_e_x;
            r_e_pay <= r_d_pay[PAYW-1:0];
        end
    end

    assign o_valid = r_e_vld;
    assign o_x     = r_e_x;
    assign o_pay   = r_e_pay;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for garner_crt_reconstruct_core: directed and random residue
// transfers under several modulus/constant settings, checked against a local predictor.
// Depends on gcr_pkg and the core RTL.
module tb_top;
    import gcr_pkg::*;

    localparam int LATENCY = 7 * 32 + 7;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

    typedef struct {
        logic [31:0] r0, r1, r2;
        bit          typed;
        logic [95:0] want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_MOD_ZERO;
    logic [FIELD_W-1:0]   i_cfg_data = '0;

    logic [31:0] mods [3];
    logic [31:0] consts [3];
    logic [95:0] pending_values [$];
    int          errors = 0;
    int          cycles = 0;
    int          stall_left = 0;
    int          rx_burst = 0;
    int          tx_burst = 0;

    always #4 i_clk = ~i_clk;

    garner_crt_reconstruct_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Garner mixed-radix rebuild, kept modulo 2^96
    function automatic logic [95:0] garner_rebuild(logic [31:0] r0, r1, r2);
        logic [127:0] acc, radix, m, xr, rr, d, u;
        logic [31:0]  res [3];
        res[0] = r0; res[1] = r1; res[2] = r2;
        acc = {96'd0, r0};
        radix = 128'd1;
        for (int i = 1; i < 3; i++) begin
            radix = radix * mods[i-1];
            m = {96'd0, mods[i]};
            u = '0;
            if (m != 0) begin
                xr = acc % m;
                rr = res[i] % m;
                d = (rr >= xr) ? rr - xr : rr + m - xr;
                u = (d * (consts[i] % m)) % m;
            end
            acc = (acc + u * radix) & {32'd0, {96{1'b1}}};
        end
        return acc[95:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MOD_ZERO:  mods[0] = val;
            CFG_MOD_ONE:   mods[1] = val;
            CFG_MOD_TWO:   mods[2] = val;
            CFG_CONST_ONE: consts[1] = val;
            CFG_CONST_TWO: consts[2] = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    // one input transfer; tvalid stays high across back-to-back items
    task automatic send(logic [31:0] r0, r1, r2, bit typed, logic [95:0] want);
        int gap;
        if (tx_burst > 0) begin
            gap = 0;
            tx_burst--;
        end else begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 15) == 0) tx_burst = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r2, r1, r0};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_values.push_back(typed ? want : garner_rebuild(r0, r1, r2));
    endtask

    function automatic logic [31:0] pick_mod();
        case ($urandom_range(0, 3))
            0: return 32'd2;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(2, 32'hFFFF_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_const();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (rx_burst > 0) begin
                rx_burst <= rx_burst - 1;
            end else begin
                stall_left <= $urandom_range(0, 13);
                if ($urandom_range(0, 15) == 0) rx_burst <= $urandom_range(10, 40);
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [95:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_values.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_values.pop_front();
                if (m_axis_tdata[63:0] !== want[63:0]) begin
                    $error("value_low expected %h got %h", want[63:0], m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== want[95:64]) begin
                    $error("value_high expected %h got %h", want[95:64],
                           m_axis_tdata[95:64]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    t_row table_rows [] = '{
        // reset settings: every stage yields u = 0, so the value is residue_zero
        '{32'h0, 32'h0, 32'h0, 1'b1, 96'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 96'hFFFF_FFFF},
        '{32'h5, 32'h1, 32'h1, 1'b1, 96'h5},
        '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_0F0F, 1'b1, 96'hA5A5_A5A5},
        // large moduli below
        '{32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{32'hFFFF_FFFA, 32'hFFFF_FFEE, 32'hFFFF_FFF0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'h1, 32'h0, 32'h0, 1'b0, '0},
        '{32'h0, 32'h1, 32'h0, 1'b0, '0},
        '{32'h0, 32'h0, 32'h1, 1'b0, '0},
        '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h3C3C_3C3C, 1'b0, '0},
        '{32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'hC3C3_C3C3, 1'b0, '0}
    };

    initial begin
        mods[0] = 2; mods[1] = 2; mods[2] = 2;
        consts[0] = 0; consts[1] = 0; consts[2] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) begin
            if (k == 4) begin
                s_axis_tvalid <= 1'b0;
                drain();
                write_reg(CFG_MOD_ZERO, 32'hFFFF_FFFB);
                write_reg(CFG_MOD_ONE, 32'hFFFF_FFEF);
                write_reg(CFG_MOD_TWO, 32'hFFFF_FFF1);
                write_reg(CFG_CONST_ONE, 32'h1234_5679);
                write_reg(CFG_CONST_TWO, 32'hFFFF_FFFF);
                write_reg(CFG_UNUSED_IDX, 32'hDEAD_BEEF);
            end
            send(table_rows[k].r0, table_rows[k].r1, table_rows[k].r2,
                 table_rows[k].typed, table_rows[k].want);
        end

        for (int ph = 0; ph < 6; ph++) begin
            s_axis_tvalid <= 1'b0;
            drain();
            if (ph == 0) begin
                write_reg(CFG_MOD_ZERO, 32'hFFFF_FFFF);
                write_reg(CFG_MOD_ONE, 32'hFFFF_FFFF);
                write_reg(CFG_MOD_TWO, 32'hFFFF_FFFF);
                write_reg(CFG_CONST_ONE, 32'hFFFF_FFFF);
                write_reg(CFG_CONST_TWO, 32'hFFFF_FFFF);
            end else begin
                write_reg(CFG_MOD_ZERO, pick_mod());
                write_reg(CFG_MOD_ONE, pick_mod());
                write_reg(CFG_MOD_TWO, pick_mod());
                write_reg(CFG_CONST_ONE, pick_const());
                write_reg(CFG_CONST_TWO, pick_const());
            end
            for (int n = 0; n < 280; n++)
                send($urandom(), $urandom(), $urandom(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        drain();

        if (errors == 0 && pending_values.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
